// ===== sv/bps_pkg.sv =====
// Package for the byte pattern search block.
// Holds the transfer payload types, register indexes and fixed field widths.
// No dependencies.
package bps_pkg;

	localparam int CFG_INDEX_BITS    = 2;
	localparam int CFG_DATA_BITS     = 64;
	localparam int LENGTH_BITS       = 5;
	localparam int PATTERN_REG_BYTES = 8;
	localparam int MATCH_OFFSET_BITS = 32;

	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH   = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} search_in_t;

	typedef struct packed {
		logic                         match_valid;
		logic [MATCH_OFFSET_BITS-1:0] match_offset;
		logic                         stream_done;
		logic                         any_match;
	} search_out_t;

endpackage

// ===== sv/byte_pattern_search.sv =====
// Top level of the byte pattern search block: window, counters, compare and result register.
// Depends on bps_pkg for the payload types, register indexes and widths.
//
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_ready     search_in_t: data_byte, end_of_data
// result    out        result_valid / result_ready search_out_t: match and end-of-stream report
// config    in         cfg_we (no wait)            cfg_index, cfg_data
//
// One byte is taken per cycle while item_ready is high; the window compare and offset
// subtract feed the result register, so a result appears in the cycle after its transfer.
// item_ready is high whenever the result register is empty or is being emptied in that cycle.
// Reset clears the window, the counters and the hit flag, and loads a pattern length of one.
// A stall on the result channel holds the result and stops further item transfers.
module byte_pattern_search
	import bps_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = 16,
	parameter int OFFSET_BITS       = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  search_in_t                item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output search_out_t               result,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int CNT_BITS = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int IDX_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

	logic [LENGTH_BITS-1:0]   pattern_length_q;
	logic [CFG_DATA_BITS-1:0] pattern_low_q;
	logic [CFG_DATA_BITS-1:0] pattern_high_q;

	logic [7:0]             window_q [MAX_PATTERN_BYTES];
	logic [7:0]             window_next [MAX_PATTERN_BYTES];
	logic [7:0]             pattern_byte [MAX_PATTERN_BYTES];
	logic [CNT_BITS-1:0]    sel_idx [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0] lane_ok;

	logic [CNT_BITS-1:0]    since_hit_q;
	logic [CNT_BITS-1:0]    since_hit_next;
	logic [OFFSET_BITS-1:0] position_q;
	logic [OFFSET_BITS-1:0] position_next;
	logic [OFFSET_BITS-1:0] start_pos;
	logic [63:0]            start_wide;
	logic                   hit_seen_q;

	logic [CNT_BITS-1:0]    len;
	logic                   hit;
	logic                   take;
	search_out_t            result_q;
	logic                   result_valid_q;

	assign item_ready   = !result_valid_q || result_ready;
	assign take         = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= LENGTH_BITS'(1);
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LENGTH_BITS-1:0];
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pattern_length_q == '0) begin
			len = CNT_BITS'(1);
		end else if (32'(pattern_length_q) > MAX_PATTERN_BYTES) begin
			len = CNT_BITS'(MAX_PATTERN_BYTES);
		end else begin
			len = CNT_BITS'(pattern_length_q);
		end
	end

	for (genvar g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_lane
		if (g < PATTERN_REG_BYTES) begin : g_low
			assign pattern_byte[g] = pattern_low_q[8*g +: 8];
		end else if (g < 2 * PATTERN_REG_BYTES) begin : g_high
			assign pattern_byte[g] = pattern_high_q[8*(g-PATTERN_REG_BYTES) +: 8];
		end else begin : g_none
			assign pattern_byte[g] = 8'd0;
		end
		if (g == 0) begin : g_head
			assign window_next[g] = item.data_byte;
		end else begin : g_tail
			assign window_next[g] = window_q[g-1];
		end
		assign sel_idx[g] = len - CNT_BITS'(1) - CNT_BITS'(g);
		assign lane_ok[g] = (CNT_BITS'(g) >= len) ||
			(pattern_byte[g] == window_next[sel_idx[g][IDX_BITS-1:0]]);
	end

	assign since_hit_next = (32'(since_hit_q) < MAX_PATTERN_BYTES) ?
		since_hit_q + CNT_BITS'(1) : since_hit_q;
	assign position_next = (position_q != '1) ? position_q + OFFSET_BITS'(1) : position_q;
	assign hit           = (since_hit_next >= len) && (&lane_ok);
	assign start_pos     = position_q - OFFSET_BITS'(len) + OFFSET_BITS'(1);
	assign start_wide    = 64'(start_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
				window_q[i] <= 8'd0;
			end
			since_hit_q <= '0;
			position_q  <= '0;
			hit_seen_q  <= 1'b0;
		end else if (take) begin
			if (item.end_of_data) begin
				for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
					window_q[i] <= 8'd0;
				end
				since_hit_q <= '0;
				position_q  <= '0;
				hit_seen_q  <= 1'b0;
			end else begin
				for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
					window_q[i] <= window_next[i];
				end
				since_hit_q <= hit ? '0 : since_hit_next;
				position_q  <= position_next;
				hit_seen_q  <= hit_seen_q || hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take && (hit || item.end_of_data)) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && (hit || item.end_of_data)) begin
			result_q.match_valid  <= hit;
			result_q.match_offset <= hit ? start_wide[MATCH_OFFSET_BITS-1:0] : '0;
			result_q.stream_done  <= item.end_of_data;
			result_q.any_match    <= hit_seen_q || hit;
		end
	end

endmodule

// ===== sim/byte_pattern_search_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for byte_pattern_search: directed and random byte streams are
// compared, result by result, with a predictor kept in step with the register writes.
// Depends on bps_pkg and the byte_pattern_search top level only.
module byte_pattern_search_test;
	import bps_pkg::*;

	localparam int WINDOW_BYTES = 16;
	localparam int SETTLE_CYCLES = 4;
	localparam int SHOWN_ERRORS = 10;
	localparam int PHASE_BYTES = 50;
	localparam int RANDOM_PHASES = 8;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      item_valid = 1'b0;
	logic                      item_ready;
	search_in_t                item = '0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	search_out_t               result;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	int idle_pct = 34;
	int error_count = 0;
	int bytes_sent = 0;

	logic [4:0]  pat_len_reg;
	logic [63:0] pat_low_reg;
	logic [63:0] pat_high_reg;
	logic [7:0]  window_bytes [WINDOW_BYTES];
	int          since_hit;
	logic [31:0] stream_pos;
	logic        hit_flag;
	search_out_t expected_reports [$];

	byte_pattern_search dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int used_length();
		int n;
		n = pat_len_reg;
		if (n == 0) begin
			n = 1;
		end
		if (n > WINDOW_BYTES) begin
			n = WINDOW_BYTES;
		end
		return n;
	endfunction

	function automatic logic [7:0] pattern_byte(input int i);
		logic [127:0] pat;
		pat = {pat_high_reg, pat_low_reg};
		return pat[8*i +: 8];
	endfunction

	function automatic void clear_stream();
		for (int i = 0; i < WINDOW_BYTES; i++) begin
			window_bytes[i] = 8'h00;
		end
		since_hit = 0;
		stream_pos = '0;
		hit_flag = 1'b0;
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic eod);
		int          len;
		logic        hit;
		logic [31:0] start;
		search_out_t rep;
		len = used_length();
		start = stream_pos - 32'(len - 1);
		for (int i = WINDOW_BYTES - 1; i > 0; i--) begin
			window_bytes[i] = window_bytes[i-1];
		end
		window_bytes[0] = b;
		if (since_hit < WINDOW_BYTES) begin
			since_hit++;
		end
		if (stream_pos != '1) begin
			stream_pos++;
		end
		hit = (since_hit >= len);
		for (int i = 0; i < len; i++) begin
			if (pattern_byte(i) != window_bytes[len-1-i]) begin
				hit = 1'b0;
			end
		end
		if (hit) begin
			hit_flag = 1'b1;
			since_hit = 0;
		end else begin
			start = '0;
		end
		if (hit || eod) begin
			rep.match_valid = hit;
			rep.match_offset = start;
			rep.stream_done = eod;
			rep.any_match = hit_flag;
			expected_reports.push_back(rep);
		end
		if (eod) begin
			clear_stream();
		end
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PATTERN_LENGTH: begin
				pat_len_reg = data[4:0];
			end
			REG_PATTERN_LOW: begin
				pat_low_reg = data;
			end
			REG_PATTERN_HIGH: begin
				pat_high_reg = data;
			end
			default: begin
			end
		endcase
	endtask

	// Registers are only written once every outstanding result has been transferred.
	task automatic drain();
		item_valid <= 1'b0;
		while (expected_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eod);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= search_in_t'{data_byte: b, end_of_data: eod};
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		predict_byte(b, eod);
		bytes_sent++;
	endtask

	task automatic configure(input logic [4:0] len, input logic two_symbols);
		logic [CFG_DATA_BITS-1:0] data;
		logic [7:0]               sym_a;
		logic [7:0]               sym_b;
		logic [127:0]             pat;
		drain();
		data = {$urandom, $urandom};
		data[4:0] = len;
		write_reg(REG_PATTERN_LENGTH, data);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		sym_a = 8'($urandom_range(255));
		sym_b = 8'($urandom_range(255));
		pat = {$urandom, $urandom, $urandom, $urandom};
		if (two_symbols) begin
			for (int i = 0; i < WINDOW_BYTES; i++) begin
				pat[8*i +: 8] = $urandom_range(1) ? sym_a : sym_b;
			end
		end
		write_reg(REG_PATTERN_LOW, pat[63:0]);
		write_reg(REG_PATTERN_HIGH, pat[127:64]);
	endtask

	task automatic test_reset_pattern();
		drain();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		drain();
		write_reg(REG_UNUSED, {$urandom, $urandom});
		send_byte(8'h00, 1'b1);
	endtask

	// A length above the window is clipped to sixteen; a stream shorter than that cannot hit.
	task automatic test_length_overflow();
		configure(5'd31, 1'b0);
		send_byte(pattern_byte(0), 1'b0);
		send_byte(pattern_byte(1), 1'b1);
		for (int i = 0; i < WINDOW_BYTES; i++) begin
			send_byte(pattern_byte(i), logic'(i == WINDOW_BYTES - 1));
		end
	endtask

	task automatic test_length_zero();
		configure(5'd0, 1'b0);
		send_byte(pattern_byte(0), 1'b0);
		send_byte(pattern_byte(0) ^ 8'hFF, 1'b1);
	endtask

	task automatic test_non_overlap();
		logic [CFG_DATA_BITS-1:0] data;
		drain();
		write_reg(REG_PATTERN_LENGTH, 64'd2);
		data = {$urandom, $urandom};
		data[15:0] = 16'h3333;
		write_reg(REG_PATTERN_LOW, data);
		for (int i = 0; i < 4; i++) begin
			send_byte(8'h33, logic'(i == 3));
		end
	endtask

	// Mostly whole copies of the pattern, some with one byte spoilt, between pattern bytes
	// and noise; streams end at random, often inside a copy.
	task automatic test_random_streams();
		logic [4:0]  len;
		int          target;
		int          choice;
		int          eff;
		int          spoilt;
		logic [7:0]  b;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: len = 5'd16;
				1: len = 5'd1;
				2: len = 5'd0;
				3: len = 5'($urandom_range(31, 17));
				default: len = 5'($urandom_range(15, 2));
			endcase
			configure(len, logic'($urandom_range(1)));
			idle_pct = (phase == 5) ? 0 : 34;
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				choice = $urandom_range(99);
				eff = used_length();
				if (choice < 50) begin
					spoilt = ($urandom_range(3) == 0) ? $urandom_range(eff - 1) : -1;
					for (int i = 0; i < eff; i++) begin
						b = pattern_byte(i);
						if (i == spoilt) begin
							b = b ^ 8'($urandom_range(255, 1));
						end
						send_byte(b, logic'($urandom_range(63) == 0));
					end
				end else if (choice < 80) begin
					send_byte(pattern_byte($urandom_range(eff - 1)),
						logic'($urandom_range(63) == 0));
				end else begin
					send_byte(8'($urandom_range(255)), logic'($urandom_range(63) == 0));
				end
			end
		end
		idle_pct = 34;
	endtask

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin : check_results
		search_out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_reports.size() == 0) begin
				error_count++;
				if (error_count <= SHOWN_ERRORS) begin
					$display("unexpected result: valid=%0b offset=%0d done=%0b any=%0b",
						result.match_valid, result.match_offset, result.stream_done,
						result.any_match);
				end
			end else begin
				want = expected_reports.pop_front();
				if (want.match_valid !== result.match_valid
						|| want.match_offset !== result.match_offset
						|| want.stream_done !== result.stream_done
						|| want.any_match !== result.any_match) begin
					error_count++;
					if (error_count <= SHOWN_ERRORS) begin
						$display("mismatch: expected valid=%0b offset=%0d done=%0b any=%0b",
							want.match_valid, want.match_offset, want.stream_done,
							want.any_match);
						$display("          actual   valid=%0b offset=%0d done=%0b any=%0b",
							result.match_valid, result.match_offset, result.stream_done,
							result.any_match);
					end
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		pat_len_reg = 5'd1;
		pat_low_reg = '0;
		pat_high_reg = '0;
		clear_stream();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_pattern();
		test_length_overflow();
		test_length_zero();
		test_non_overlap();
		test_random_streams();
		drain();
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
